### sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define MTBI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define MTBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/mtbi_pkg.sv
package mtbi_pkg;

  localparam int unsigned MAX_ROWS_DEF    = 1024;
  localparam int unsigned MAX_COLUMNS_DEF = 16;
  localparam int unsigned QUEUE_DEPTH     = 4;

  localparam logic [1:0] CFG_CV1_COUNT = 2'd0;
  localparam logic [1:0] CFG_CV2_COUNT = 2'd1;
  localparam logic [1:0] CFG_VAR_COUNT = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [3:0] COL_CV1 = 4'd0;
  localparam logic [3:0] COL_CV2 = 4'd1;

  localparam logic [16:0]        ONE_Q16 = 17'd65536;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] Q16_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic               opcode;
    logic [9:0]         write_row;
    logic [3:0]         write_column;
    logic signed [31:0] write_value;
    logic signed [31:0] query_cv1;
    logic signed [31:0] query_cv2;
    logic [3:0]         query_column;
  } in_t;

  typedef struct packed {
    logic signed [31:0] interpolated_value;
    logic               status;
  } out_t;

  typedef struct packed {
    logic [10:0] cv1_count;
    logic [10:0] cv2_count;
    logic [4:0]  var_count;
    logic [21:0] rows;
    logic        sizes_ok;
  } cfg_t;

  typedef struct packed {
    logic err;
    in_t  item;
  } qent_t;

endpackage

### sv/mtbi_fifo.sv
module mtbi_fifo
  import mtbi_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  qent_t data_i,
  input  logic  pop_i,
  output qent_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  qent_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? PW'(wr_q + 1'b1) : wr_q;
    rd_d  = pop_i ? PW'(rd_q + 1'b1) : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = CW'(cnt_q + 1'b1);
    end else if (!push_i && pop_i) begin
      cnt_d = CW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule

### sv/mtbi_front.sv
module mtbi_front
  import mtbi_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        start_i,
  input  logic        full_i,
  input  in_t         in_i,
  output logic        push_o,
  output qent_t       entry_o,
  output cfg_t        cfg_o
);

  logic [10:0] cv1_q, cv2_q;
  logic [4:0]  var_q;
  logic [21:0] rows;
  logic        sizes_ok, qcol_ok, wr_ok, is_query;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv1_q <= 11'd2;
      cv2_q <= 11'd2;
      var_q <= 5'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CV1_COUNT: cv1_q <= cfg_data_i;
        CFG_CV2_COUNT: cv2_q <= cfg_data_i;
        CFG_VAR_COUNT: var_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  assign rows     = 22'(cv1_q) * 22'(cv2_q);
  assign sizes_ok = (cv1_q >= 11'd2) && (cv2_q >= 11'd2) && (rows <= 22'(MAX_ROWS))
                    && (var_q >= 5'd2) && ({2'b00, var_q} <= 7'(MAX_COLUMNS));
  assign is_query = (in_i.opcode == OP_QUERY);
  assign qcol_ok  = ({1'b0, in_i.query_column} < var_q);
  assign wr_ok    = sizes_ok && (22'(in_i.write_row) < rows)
                    && ({1'b0, in_i.write_column} < var_q);

  assign push_o       = start_i && !full_i && (is_query || wr_ok);
  assign entry_o.err  = is_query && !(sizes_ok && qcol_ok);
  assign entry_o.item = in_i;

  assign cfg_o.cv1_count = cv1_q;
  assign cfg_o.cv2_count = cv2_q;
  assign cfg_o.var_count = var_q;
  assign cfg_o.rows      = rows;
  assign cfg_o.sizes_ok  = sizes_ok;

endmodule

### sv/mtbi_div.sv
module mtbi_div
  import mtbi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] lo_i,
  input  logic signed [31:0] hi_i,
  output logic               done_o,
  output logic [16:0]        eta_o
);

  logic               busy_q, done_q;
  logic [3:0]         cnt_q;
  logic [31:0]        rem_q, den_q, rem_nx;
  logic [16:0]        q_q;
  logic signed [32:0] span, num;
  logic [32:0]        r2;
  logic               ge, sp_zero, sp_one;

  assign span    = 33'(hi_i) - 33'(lo_i);
  assign num     = 33'(x_i) - 33'(lo_i);
  assign sp_zero = span[32] || (span == '0) || num[32] || (num == '0);
  assign sp_one  = (num >= span);
  assign r2      = {rem_q, 1'b0};
  assign ge      = (r2 >= {1'b0, den_q});
  assign rem_nx  = ge ? 32'(r2 - {1'b0, den_q}) : r2[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= !(sp_zero || sp_one);
        done_q <= sp_zero || sp_one;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= 4'(cnt_q + 1'b1);
        if (cnt_q == 4'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num[31:0];
      den_q <= span[31:0];
      q_q   <= sp_zero ? 17'd0 : (sp_one ? ONE_Q16 : 17'd0);
    end else if (busy_q) begin
      rem_q <= rem_nx;
      q_q   <= {q_q[15:0], ge};
    end
  end

  assign done_o = done_q;
  assign eta_o  = q_q;

endmodule

### sv/mtbi_back.sv
module mtbi_back
  import mtbi_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  empty_i,
  input  qent_t entry_i,
  output logic  pop_o,
  output logic  result_valid_o,
  output out_t  result_o
);

  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [13:0] {
    ST_IDLE = 14'b00000000000001,
    ST_LIM  = 14'b00000000000010,
    ST_HI   = 14'b00000000000100,
    ST_DIV1 = 14'b00000000001000,
    ST_LOC1 = 14'b00000000010000,
    ST_BASE = 14'b00000000100000,
    ST_RDB  = 14'b00000001000000,
    ST_MB   = 14'b00000010000000,
    ST_DIV2 = 14'b00000100000000,
    ST_LOC2 = 14'b00001000000000,
    ST_RDV  = 14'b00010000000000,
    ST_WGT  = 14'b00100000000000,
    ST_MV   = 14'b01000000000000,
    ST_OUT  = 14'b10000000000000
  } state_e;

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] row, input logic [3:0] col);
    addr_of = AW'(AW'(row) * AW'(MAX_COLUMNS) + AW'(col));
  endfunction

  state_e             state_q, state_d;
  logic [3:0]         cnt_q, cnt_d;
  logic [1:0]         cnt_m1;
  logic               start_q, start_d, valid_q, valid_d;

  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_q;
  logic [AW-1:0]      rd_addr;
  logic [RW-1:0]      rd_row, n2r, b2;
  logic               wr_en;

  logic signed [31:0] cv1_q, cv2_q, lo_q, hi_q, largest1_q, largest2_q;
  logic [3:0]         col_q;
  logic [16:0]        eta_q, w1p_q, w1m_q, w2p_q, w2m_q;
  logic [RW-1:0]      i1_q, i2_q, base_q;
  logic signed [31:0] t_q [4];
  logic [32:0]        wt_q [4];
  logic signed [49:0] prod_q, mprod;
  logic [16:0]        mul_a;
  logic signed [31:0] mul_b;
  logic               sh_q;
  logic signed [65:0] acc_q, bsum, term, fsum;
  logic signed [33:0] fr;
  out_t               res_q;

  logic [10:0]        loc_n;
  logic [27:0]        loc_pos;
  logic [11:0]        loc_i, loc_lim, loc_ic;
  logic [16:0]        loc_wp;

  logic               div_done;
  logic [16:0]        div_eta;
  logic signed [31:0] div_x;

  logic               is_query;
  logic signed [31:0] qcv1, qcv2, wval;

  assign is_query = (entry_i.item.opcode == OP_QUERY);
  assign qcv1     = entry_i.item.query_cv1;
  assign qcv2     = entry_i.item.query_cv2;
  assign wval     = entry_i.item.write_value;
  assign cnt_m1   = 2'(cnt_q - 4'd1);
  assign n2r      = RW'(cfg_i.cv2_count);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    start_d = 1'b0;
    valid_d = 1'b0;
    pop_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (is_query) begin
            if (entry_i.err) begin
              valid_d = 1'b1;
            end else begin
              state_d = ST_LIM;
            end
          end
        end
      end
      ST_LIM: state_d = ST_HI;
      ST_HI: begin
        state_d = ST_DIV1;
        start_d = 1'b1;
      end
      ST_DIV1: begin
        if (!start_q && div_done) state_d = ST_LOC1;
      end
      ST_LOC1: state_d = ST_BASE;
      ST_BASE: begin
        state_d = ST_RDB;
        cnt_d   = '0;
      end
      ST_RDB: begin
        if (cnt_q == 4'd4) begin
          state_d = ST_MB;
          cnt_d   = '0;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end
      ST_MB: begin
        if (cnt_q == 4'd4) begin
          state_d = ST_DIV2;
          start_d = 1'b1;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end
      ST_DIV2: begin
        if (!start_q && div_done) state_d = ST_LOC2;
      end
      ST_LOC2: begin
        state_d = ST_RDV;
        cnt_d   = '0;
      end
      ST_RDV: begin
        if (cnt_q == 4'd4) begin
          state_d = ST_WGT;
          cnt_d   = '0;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end
      ST_WGT: begin
        if (cnt_q == 4'd4) begin
          state_d = ST_MV;
          cnt_d   = '0;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end
      ST_MV: begin
        if (cnt_q == 4'd8) begin
          state_d = ST_OUT;
        end else begin
          cnt_d = 4'(cnt_q + 1'b1);
        end
      end
      ST_OUT: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      start_q    <= 1'b0;
      valid_q    <= 1'b0;
      largest1_q <= Q16_MIN;
      largest2_q <= Q16_MIN;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      valid_q <= valid_d;
      if (wr_en) begin
        if (entry_i.item.write_column == COL_CV1 && wval > largest1_q) largest1_q <= wval;
        if (entry_i.item.write_column == COL_CV2 && wval > largest2_q) largest2_q <= wval;
      end
    end
  end

  // Table memory: one write and one registered read per cycle.
  assign wr_en = (state_q == ST_IDLE) && !empty_i && !is_query;

  always_comb begin
    b2     = RW'(base_q + i2_q);
    rd_row = '0;
    case (cnt_q[1:0])
      2'd0: rd_row = (state_q == ST_RDB) ? base_q : b2;
      2'd1: rd_row = (state_q == ST_RDB) ? RW'(base_q + n2r) : RW'(b2 + RW'(1));
      2'd2: rd_row = (state_q == ST_RDB) ? RW'(base_q + n2r - RW'(1)) : RW'(b2 + n2r);
      2'd3: rd_row = (state_q == ST_RDB) ? RW'(base_q + n2r + n2r - RW'(1))
                                         : RW'(b2 + n2r + RW'(1));
      default: rd_row = '0;
    endcase
    case (state_q)
      ST_LIM:  rd_addr = addr_of(RW'(cfg_i.rows - 22'd1), COL_CV1);
      ST_RDB:  rd_addr = addr_of(rd_row, COL_CV2);
      ST_RDV:  rd_addr = addr_of(rd_row, col_q);
      default: rd_addr = addr_of('0, COL_CV1);
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr_of(RW'(entry_i.item.write_row), entry_i.item.write_column)] <= wval;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Grid locate: position, lower index and upper weight.
  assign loc_n   = (state_q == ST_LOC1) ? cfg_i.cv1_count : cfg_i.cv2_count;
  assign loc_pos = 28'(eta_q) * 28'(loc_n - 11'd1);
  assign loc_i   = loc_pos[27:16];
  assign loc_lim = 12'(loc_n - 11'd2);
  assign loc_ic  = (loc_i > loc_lim) ? loc_lim : loc_i;
  assign loc_wp  = 17'(loc_pos - {loc_ic, 16'b0});

  // Shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MB: begin
        mul_a = cnt_q[0] ? w1p_q : w1m_q;
        mul_b = t_q[cnt_q[1:0]];
      end
      ST_WGT: begin
        mul_a = cnt_q[1] ? w1p_q : w1m_q;
        mul_b = $signed({15'b0, (cnt_q[0] ? w2p_q : w2m_q)});
      end
      ST_MV: begin
        mul_a = cnt_q[0] ? wt_q[cnt_q[2:1]][32:16] : {1'b0, wt_q[cnt_q[2:1]][15:0]};
        mul_b = t_q[cnt_q[2:1]];
      end
      default: ;
    endcase
  end

  assign mprod = $signed({1'b0, mul_a}) * mul_b;
  assign bsum  = acc_q + 66'(prod_q) + 66'sd32768;
  assign term  = sh_q ? (66'(prod_q) <<< 16) : 66'(prod_q);
  assign fsum  = acc_q + 66'sd2147483648;
  assign fr    = fsum[65:32];
  assign div_x = (state_q == ST_DIV2) ? cv2_q : cv1_q;

  always_ff @(posedge clk_i) begin
    prod_q <= mprod;
    sh_q   <= cnt_q[0];
    if (div_done) eta_q <= div_eta;
    case (state_q)
      ST_IDLE: begin
        cv1_q <= (qcv1 > largest1_q) ? largest1_q : qcv1;
        cv2_q <= (qcv2 > largest2_q) ? largest2_q : qcv2;
        col_q <= entry_i.item.query_column;
        res_q.interpolated_value <= '0;
        res_q.status             <= STATUS_ERR;
      end
      ST_LIM: lo_q <= rd_q;
      ST_HI:  hi_q <= rd_q;
      ST_LOC1: begin
        i1_q  <= RW'(loc_ic);
        w1p_q <= loc_wp;
        w1m_q <= 17'(ONE_Q16 - loc_wp);
      end
      ST_BASE: base_q <= RW'(i1_q * n2r);
      ST_RDB, ST_RDV: begin
        if (cnt_q != 4'd0) t_q[cnt_m1] <= rd_q;
      end
      ST_MB: begin
        case (cnt_q)
          4'd1, 4'd3: acc_q <= 66'(prod_q);
          4'd2: lo_q <= bsum[47:16];
          4'd4: hi_q <= bsum[47:16];
          default: ;
        endcase
      end
      ST_LOC2: begin
        i2_q  <= RW'(loc_ic);
        w2p_q <= loc_wp;
        w2m_q <= 17'(ONE_Q16 - loc_wp);
      end
      ST_WGT: begin
        if (cnt_q != 4'd0) wt_q[cnt_m1] <= prod_q[32:0];
      end
      ST_MV: begin
        if (cnt_q == 4'd1) begin
          acc_q <= term;
        end else if (cnt_q != 4'd0) begin
          acc_q <= acc_q + term;
        end
      end
      ST_OUT: begin
        res_q.status <= STATUS_OK;
        if (fr > 34'sd2147483647) begin
          res_q.interpolated_value <= Q16_MAX;
        end else if (fr < -34'sd2147483648) begin
          res_q.interpolated_value <= Q16_MIN;
        end else begin
          res_q.interpolated_value <= fr[31:0];
        end
      end
      default: ;
    endcase
  end

  mtbi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .x_i     (div_x),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .done_o  (div_done),
    .eta_o   (div_eta)
  );

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

### sv/manifold_table_bilinear_interp.sv
// Channel   | Handshake                    | Payload
// ----------+------------------------------+--------------------
// input     | start, busy (start & !busy)  | in_i (in_t)
// result    | result_valid_o, one cycle    | result_o (out_t)
// config    | cfg_we_i, cfg_idx_i          | cfg_data_i
//
// A word enters a four-deep queue in the cycle it is accepted, but an invalid write is
// dropped; busy is high only while the queue is full. A table write is stored as it leaves
// the queue and gives no result; a rejected query gives its error result in the cycle after
// it leaves the queue. A valid query runs two divisions of up to 16 steps and uses a single shared
// multiplier that forms the bound blends, the weights and the eight value partial products.
// Reset clears the queue, the sequencer and the column maxima; table contents are kept.
// The receiver cannot stall; each result is shown for exactly one cycle.
module manifold_table_bilinear_interp
  import mtbi_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [10:0] cfg_data_i,
  input  logic        start,
  output logic        busy,
  input  in_t         in_i,
  output logic        result_valid_o,
  output out_t        result_o
);

  logic  push, pop, full, empty;
  qent_t push_entry, pop_entry;
  cfg_t  cfg;

  mtbi_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .start_i    (start),
    .full_i     (full),
    .in_i       (in_i),
    .push_o     (push),
    .entry_o    (push_entry),
    .cfg_o      (cfg)
  );

  mtbi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  mtbi_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .empty_i        (empty),
    .entry_i        (pop_entry),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  assign busy = full;

endmodule

### sv/mtbi_checker.sv
`include "assert_macros.svh"

module mtbi_checker
  import mtbi_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic result_valid_o,
  input out_t result_o
);

  logic err_word, ok_word, zero_val;

  assign err_word = result_valid_o && (result_o.status == STATUS_ERR);
  assign ok_word  = result_valid_o && (result_o.status == STATUS_OK);
  assign zero_val = (result_o.interpolated_value == '0);

  `MTBI_ASSERT(a_err_zero, clk_i, rst_ni, err_word |-> zero_val, "error word carries a value")
  `MTBI_ASSERT(a_busy_cause, clk_i, rst_ni, $rose(busy) |-> $past(start), "busy rose with no word")
  `MTBI_ASSERT(a_busy_hold, clk_i, rst_ni, !busy && !start |=> !busy, "busy rose while idle")
  `MTBI_ASSERT(a_ok_gap, clk_i, rst_ni, ok_word |-> !$past(result_valid_o), "words back to back")

endmodule

bind manifold_table_bilinear_interp mtbi_checker u_mtbi_checker (.*);

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import mtbi_pkg::*;

  typedef struct {
    in_t  word;
    bit   typed;
    out_t res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [10:0] cfg_data_i;
  logic        start;
  logic        busy;
  in_t         in_i;
  logic        result_valid_o;
  out_t        result_o;

  manifold_table_bilinear_interp u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .start          (start),
    .busy           (busy),
    .in_i           (in_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Shadow copy of the table, the column maxima and the geometry registers.
  logic signed [31:0] grid_val[1024][16];
  bit                 grid_set[1024][16];
  longint             top_cv1;
  longint             top_cv2;
  int unsigned        n_cv1;
  int unsigned        n_cv2;
  int unsigned        n_var;

  out_t        interp_q[$];
  int unsigned words_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned phases_run;
  bit          no_idle;

  // Grid shape of the current table fill, used to aim queries.
  longint base1, step1, base2, step2, skew2;

  dir_row_t dir_rows[$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic bit geometry_ok();
    return n_cv1 >= 2 && n_cv2 >= 2 && n_cv1 * n_cv2 <= 1024 && n_var >= 2 && n_var <= 16;
  endfunction

  function automatic longint cell_at(input int unsigned row, input int unsigned col,
                                     inout bit unset);
    if (!grid_set[row % 1024][col % 16]) unset = 1'b1;
    return longint'(grid_val[row % 1024][col % 16]);
  endfunction

  function automatic longint frac_q16(input longint x, input longint lo, input longint hi);
    longint span;
    longint num;
    span = hi - lo;
    num  = x - lo;
    if (span <= 0 || num <= 0) return 0;
    if (num >= span) return 65536;
    return (num * 65536) / span;
  endfunction

  function automatic void grid_pos(input longint eta, input int unsigned n,
                                   output int unsigned idx, output longint wp);
    longint nn;
    longint pos;
    longint i;
    nn  = n;
    pos = eta * (nn - 1);
    i   = pos >>> 16;
    if (i > nn - 2) i = nn - 2;
    idx = 32'(i);
    wp  = pos - (i <<< 16);
  endfunction

  function automatic longint mix_q16(input longint wm, input longint a, input longint wp,
                                     input longint b);
    return (wm * a + wp * b + 32768) >>> 16;
  endfunction

  // Expected result of a query; unset flags a read of a never written entry.
  function automatic void interp_expect(input in_t w, output out_t r, output bit unset);
    longint      c1, c2, lo, hi, acc, w1p, w1m, w2p, w2m;
    int unsigned i1, i2, rows, col;
    unset                = 1'b0;
    r.interpolated_value = '0;
    r.status             = STATUS_OK;
    col                  = w.query_column;
    if (!geometry_ok() || col >= n_var) begin
      r.status = STATUS_ERR;
      return;
    end
    rows = n_cv1 * n_cv2;
    c1 = w.query_cv1;
    if (c1 > top_cv1) c1 = top_cv1;
    c2 = w.query_cv2;
    if (c2 > top_cv2) c2 = top_cv2;
    grid_pos(frac_q16(c1, cell_at(0, 0, unset), cell_at(rows - 1, 0, unset)), n_cv1, i1, w1p);
    w1m = 65536 - w1p;
    lo = mix_q16(w1m, cell_at(i1 * n_cv2, 1, unset), w1p, cell_at((i1 + 1) * n_cv2, 1, unset));
    hi = mix_q16(w1m, cell_at((i1 + 1) * n_cv2 - 1, 1, unset),
                 w1p, cell_at((i1 + 2) * n_cv2 - 1, 1, unset));
    grid_pos(frac_q16(c2, lo, hi), n_cv2, i2, w2p);
    w2m = 65536 - w2p;
    acc = (w1m * w2m) * cell_at(i2 + i1 * n_cv2, col, unset)
        + (w1m * w2p) * cell_at(i2 + 1 + i1 * n_cv2, col, unset)
        + (w1p * w2m) * cell_at(i2 + (i1 + 1) * n_cv2, col, unset)
        + (w1p * w2p) * cell_at(i2 + 1 + (i1 + 1) * n_cv2, col, unset);
    acc = (acc + 64'sh8000_0000) >>> 32;
    if (acc > 64'sh7fff_ffff) acc = 64'sh7fff_ffff;
    if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
    r.interpolated_value = acc[31:0];
  endfunction

  function automatic void table_store(input in_t w);
    longint v;
    v = w.write_value;
    if (!geometry_ok() || w.write_row >= n_cv1 * n_cv2 || w.write_column >= n_var) return;
    grid_val[w.write_row][w.write_column] = w.write_value;
    grid_set[w.write_row][w.write_column] = 1'b1;
    if (w.write_column == COL_CV1 && v > top_cv1) top_cv1 = v;
    if (w.write_column == COL_CV2 && v > top_cv2) top_cv2 = v;
  endfunction

  function automatic in_t mk_write(input int unsigned row, input int unsigned col,
                                   input logic [31:0] val);
    in_t w;
    w              = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom});
    w.opcode       = OP_WRITE;
    w.write_row    = 10'(row);
    w.write_column = 4'(col);
    w.write_value  = val;
    return w;
  endfunction

  function automatic in_t mk_query(input logic [31:0] cv1, input logic [31:0] cv2,
                                   input int unsigned col);
    in_t w;
    w              = $bits(in_t)'({$urandom, $urandom, $urandom, $urandom});
    w.opcode       = OP_QUERY;
    w.query_cv1    = cv1;
    w.query_cv2    = cv2;
    w.query_column = 4'(col);
    return w;
  endfunction

  task automatic send_word(input in_t w, input bit typed, input out_t typed_res);
    out_t r;
    bit   unset;
    start <= 1'b1;
    in_i  <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    words_sent++;
    if (w.opcode == OP_QUERY) begin
      interp_expect(w, r, unset);
      interp_q.push_back(typed ? typed_res : r);
    end else begin
      table_store(w);
    end
    if (!no_idle && $urandom_range(0, 5) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic drain_all();
    start <= 1'b0;
    @(posedge clk_i);
    while (interp_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_geometry(input logic [10:0] a, input logic [10:0] b,
                                input logic [10:0] c);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CV1_COUNT;
    cfg_data_i <= a;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_CV2_COUNT;
    cfg_data_i <= b;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_VAR_COUNT;
    cfg_data_i <= c;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    n_cv1 = a;
    n_cv2 = b;
    n_var = c[4:0];
  endtask

  task automatic fill_grid();
    int unsigned     rows, a, b;
    logic [31:0]     v;
    out_t            none;
    none  = '0;
    rows  = n_cv1 * n_cv2;
    base1 = longint'($urandom_range(0, 32'h80_0000)) - 32'h40_0000;
    step1 = $urandom_range(32'h100, 32'h2_0000);
    base2 = longint'($urandom_range(0, 32'h80_0000)) - 32'h40_0000;
    step2 = $urandom_range(32'h100, 32'h2_0000);
    skew2 = $urandom_range(0, 32'h800);
    for (int unsigned r = 0; r < rows; r++) begin
      a = r / n_cv2;
      b = r % n_cv2;
      if ((b < 8 || b >= n_cv2 - 8) && (a < 4 || a >= n_cv1 - 4)) begin
        for (int unsigned c = 0; c < n_var; c++) begin
          if (c == 0) v = 32'(base1 + a * step1);
          else if (c == 1) v = 32'(base2 + b * step2 + a * skew2);
          else v = $urandom;
          if ($urandom_range(0, 32) == 0) v = $urandom;
          send_word(mk_write(r, c, v), 1'b0, none);
        end
      end
    end
  endtask

  task automatic random_items(input int unsigned count);
    in_t         w;
    out_t        r;
    bit          unset;
    bit          found;
    logic [31:0] cv1, cv2;
    for (int unsigned k = 0; k < count; k++) begin
      found = 1'b0;
      if (geometry_ok() && $urandom_range(0, 6) != 0) begin
        for (int t = 0; t < 30 && !found; t++) begin
          cv1 = 32'(base1 - step1 + $urandom_range(0, (n_cv1 + 1) * step1));
          cv2 = 32'(base2 - step2 + $urandom_range(0, (n_cv2 + 1) * step2 + n_cv1 * skew2));
          if ($urandom_range(0, 4) == 0) cv1 = $urandom;
          if ($urandom_range(0, 4) == 0) cv2 = $urandom;
          w = mk_query(cv1, cv2, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15)
                                                             : $urandom_range(0, n_var - 1));
          interp_expect(w, r, unset);
          found = !unset;
        end
      end
      if (!found) begin
        if ($urandom_range(0, 1) == 0)
          w = mk_query($urandom, $urandom, $urandom_range(0, 15));
        else
          w = mk_write($urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
        interp_expect(w, r, unset);
        if (w.opcode == OP_QUERY && unset)
          w = mk_write($urandom_range(0, 1023), $urandom_range(0, 15), $urandom);
      end
      r = '0;
      send_word(w, 1'b0, r);
    end
  endtask

  task automatic run_phase(input logic [10:0] a, input logic [10:0] b, input logic [10:0] c,
                           input int unsigned count);
    drain_all();
    write_geometry(a, b, c);
    if (geometry_ok()) fill_grid();
    random_items(count);
    phases_run++;
  endtask

  function automatic void add_row(input in_t w, input bit typed, input logic [31:0] v,
                                  input logic st);
    dir_row_t d;
    d.word                   = w;
    d.typed                  = typed;
    d.res.interpolated_value = v;
    d.res.status             = st;
    dir_rows.push_back(d);
  endfunction

  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (interp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word: value %h status %b",
                   result_o.interpolated_value, result_o.status);
      end else begin
        e = interp_q.pop_front();
        if (result_o.interpolated_value !== e.interpolated_value ||
            result_o.status !== e.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected value %h status %b, got value %h status %b",
                     e.interpolated_value, e.status,
                     result_o.interpolated_value, result_o.status);
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_CV1_COUNT;
    cfg_data_i   = '0;
    start        = 1'b0;
    in_i         = '0;
    no_idle      = 1'b0;
    words_sent   = 0;
    results_seen = 0;
    mismatches   = 0;
    phases_run   = 0;
    top_cv1      = -64'sh8000_0000;
    top_cv2      = -64'sh8000_0000;
    n_cv1        = 2;
    n_cv2        = 2;
    n_var        = 2;
    foreach (grid_set[i, j]) grid_set[i][j] = 1'b0;
    base1 = 0;
    step1 = 32'h1_0000;
    base2 = 0;
    step2 = 32'h1_0000;
    skew2 = 0;

    add_row(mk_query(Q16_MIN, Q16_MAX, 2), 1'b1, '0, STATUS_ERR);
    add_row(mk_query(Q16_MAX, Q16_MIN, 15), 1'b1, '0, STATUS_ERR);
    add_row(mk_write(4, 0, 32'h1_2345), 1'b0, '0, STATUS_OK);
    add_row(mk_write(0, 2, 32'h1_2345), 1'b0, '0, STATUS_OK);
    add_row(mk_write(0, 0, 32'h0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(1, 0, 32'h0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(2, 0, 32'hA_0000), 1'b0, '0, STATUS_OK);
    add_row(mk_write(3, 0, 32'hA_0000), 1'b0, '0, STATUS_OK);
    add_row(mk_write(0, 1, 32'h0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(1, 1, 32'h5_0000), 1'b0, '0, STATUS_OK);
    add_row(mk_write(2, 1, 32'h0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(3, 1, 32'h5_0000), 1'b0, '0, STATUS_OK);
    add_row(mk_query(Q16_MIN, Q16_MAX, 1), 1'b1, 32'h5_0000, STATUS_OK);
    add_row(mk_query(Q16_MAX, Q16_MIN, 0), 1'b1, 32'hA_0000, STATUS_OK);
    add_row(mk_query(32'h5_0000, 32'h2_8000, 1), 1'b0, '0, STATUS_OK);
    add_row(mk_query(32'h1_2345, 32'h3_ffff, 0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(3, 1, Q16_MAX), 1'b0, '0, STATUS_OK);
    add_row(mk_write(0, 0, Q16_MIN), 1'b0, '0, STATUS_OK);
    add_row(mk_query(32'h0, Q16_MAX, 1), 1'b0, '0, STATUS_OK);
    add_row(mk_write(1, 1, Q16_MIN), 1'b0, '0, STATUS_OK);
    add_row(mk_query(Q16_MAX, 32'h0, 1), 1'b0, '0, STATUS_OK);
    add_row(mk_query(32'hFFFF_0000, 32'h7000_0000, 0), 1'b0, '0, STATUS_OK);
    add_row(mk_write(1023, 15, 32'hFFFF_FFFF), 1'b0, '0, STATUS_OK);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].res);

    run_phase(11'd3, 11'd4, 11'd5, 110);
    run_phase(11'd1, 11'd2, 11'd2, 25);
    run_phase(11'd4, 11'd3, 11'd16, 110);
    run_phase(11'd2047, 11'd2047, 11'h7FF, 25);
    run_phase(11'd5, 11'd5, 11'd9, 110);
    run_phase(11'd2, 11'd512, 11'd2, 110);
    run_phase(11'd1024, 11'd1024, 11'd16, 25);
    run_phase(11'd512, 11'd2, 11'd3, 110);
    run_phase(11'd2, 11'd2, 11'd17, 25);
    run_phase(11'd0, 11'd0, 11'd0, 25);
    no_idle = 1'b1;
    run_phase(11'd3, 11'd3, 11'd4, 110);
    drain_all();

    if (interp_q.size() != 0) mismatches++;
    $display("Sent %0d words over %0d table geometries, %0d results checked.",
             words_sent, phases_run + 1, results_seen);
    $display("Geometries spanned minimum, maximum and out of range sizes and column counts.");
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+sv
sv/mtbi_pkg.sv
sv/mtbi_fifo.sv
sv/mtbi_front.sv
sv/mtbi_div.sv
sv/mtbi_back.sv
sv/manifold_table_bilinear_interp.sv
sv/mtbi_checker.sv
test/tb_top.sv
